FILE: rtl/cccu_pkg.sv
// Shared types, codes and calendar helper functions for the calendar clock counter.
`timescale 1ns / 1ps

package cccu_pkg;

    localparam logic [13:0] YEAR_TOP   = 14'd9999;
    localparam logic [13:0] YEAR_RESET = 14'd2000;
    localparam logic [5:0]  SEC_TOP    = 6'd59;
    localparam logic [5:0]  MIN_TOP    = 6'd59;
    localparam logic [4:0]  HOUR_TOP   = 5'd23;
    localparam logic [3:0]  MONTH_TOP  = 4'd12;
    localparam logic [4:0]  LEAP_FEB   = 5'd29;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;

    // floor(yr / 100) = (yr * 5243) >> 19, exact for 14-bit years
    localparam logic [26:0] DIV100_MUL   = 27'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic [4:0] MONTH_DAYS [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    typedef enum logic [1:0] {
        FUNC_FWD  = 2'd0,
        FUNC_BACK = 2'd1,
        FUNC_LOAD = 2'd2,
        FUNC_HOLD = 2'd3
    } func_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_time_t;

    function automatic logic is_leap(logic [13:0] yr);
        logic [26:0] prod;
        logic [7:0]  q;
        logic [13:0] hund;
        prod = 27'(yr) * DIV100_MUL;
        q    = prod[DIV100_SHIFT +: 8];
        hund = 14'({q, 6'd0}) + 14'({q, 5'd0}) + 14'({q, 2'd0});
        return (yr[1:0] == 2'b00) && ((yr != hund) || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [4:0] month_len(logic [3:0] mon, logic leap);
        logic [4:0] len;
        len = MONTH_DAYS[mon];
        if ((mon == MONTH_FEB) && leap) begin
            len = LEAP_FEB;
        end
        return len;
    endfunction

endpackage

FILE: rtl/calendar_clock_up_down_counter_unit.sv
// Top level: input word register, next-state logic and counter/result register.
// Throughput: one word per cycle while results are taken; a new word is taken
// while a result waits if the input register is empty. The counter register
// doubles as the result register; it advances only when the result slot is
// free. Synchronous active-low reset sets 2000-01-01 00:00:00 and empties both
// stages.
`timescale 1ns / 1ps

module calendar_clock_up_down_counter_unit
    import cccu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [5:0]  s_load_second,
    input  logic [5:0]  s_load_minute,
    input  logic [4:0]  s_load_hour,
    input  logic [4:0]  s_load_day,
    input  logic [3:0]  s_load_month,
    input  logic [13:0] s_load_year,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_cur_second,
    output logic [5:0]  m_cur_minute,
    output logic [4:0]  m_cur_hour,
    output logic [4:0]  m_cur_day,
    output logic [3:0]  m_cur_month,
    output logic [13:0] m_cur_year
);

    logic      in_valid_reg;
    func_t     in_func_reg;
    cal_time_t in_load_reg;
    logic      out_valid_reg;
    cal_time_t state_reg;
    cal_time_t state_next;
    logic      advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    cccu_step u_step (
        .cur  (state_reg),
        .func (in_func_reg),
        .load (in_load_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg        <= func_t'(s_func);
            in_load_reg.second <= s_load_second;
            in_load_reg.minute <= s_load_minute;
            in_load_reg.hour   <= s_load_hour;
            in_load_reg.day    <= s_load_day;
            in_load_reg.month  <= s_load_month;
            in_load_reg.year   <= s_load_year;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.second <= '0;
            state_reg.minute <= '0;
            state_reg.hour   <= '0;
            state_reg.day    <= 5'd1;
            state_reg.month  <= 4'd1;
            state_reg.year   <= YEAR_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_cur_second = state_reg.second;
    assign m_cur_minute = state_reg.minute;
    assign m_cur_hour   = state_reg.hour;
    assign m_cur_day    = state_reg.day;
    assign m_cur_month  = state_reg.month;
    assign m_cur_year   = state_reg.year;

endmodule

FILE: rtl/cccu_step.sv
// Next-state logic: one-second tick forward or back, load, or hold, with date carry.
`timescale 1ns / 1ps

module cccu_step
    import cccu_pkg::*;
(
    input  cal_time_t cur,
    input  func_t     func,
    input  cal_time_t load,
    output cal_time_t nxt
);

    logic       leap;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] mon_inc;
    logic [4:0] day_dec;
    logic [3:0] mon_dec;
    cal_time_t  fwd;
    cal_time_t  back;

    assign leap = is_leap(cur.year);

    always_comb begin
        fwd      = cur;
        sec_inc  = 7'(cur.second) + 7'd1;
        min_inc  = 7'(cur.minute) + 7'd1;
        hour_inc = 6'(cur.hour) + 6'd1;
        day_inc  = 6'(cur.day) + 6'd1;
        mon_inc  = 5'(cur.month) + 5'd1;
        fwd.second = sec_inc[5:0];
        if (sec_inc > 7'(SEC_TOP)) begin
            fwd.second = '0;
            fwd.minute = min_inc[5:0];
            if (min_inc > 7'(MIN_TOP)) begin
                fwd.minute = '0;
                fwd.hour   = hour_inc[4:0];
                if (hour_inc > 6'(HOUR_TOP)) begin
                    fwd.hour = '0;
                    fwd.day  = day_inc[4:0];
                    if (day_inc > 6'(month_len(cur.month, leap))) begin
                        fwd.day   = 5'd1;
                        fwd.month = mon_inc[3:0];
                        if (mon_inc > 5'(MONTH_TOP)) begin
                            fwd.month = 4'd1;
                            fwd.year  = (cur.year >= YEAR_TOP) ? '0 : cur.year + 14'd1;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        back    = cur;
        day_dec = cur.day - 5'd1;
        mon_dec = cur.month - 4'd1;
        if (cur.second != '0) begin
            back.second = cur.second - 6'd1;
        end else begin
            back.second = SEC_TOP;
            if (cur.minute != '0) begin
                back.minute = cur.minute - 6'd1;
            end else begin
                back.minute = MIN_TOP;
                if (cur.hour != '0) begin
                    back.hour = cur.hour - 5'd1;
                end else begin
                    back.hour = HOUR_TOP;
                    back.day  = day_dec;
                    if (day_dec == '0) begin
                        // December is 31 days whatever the year
                        if (mon_dec == '0) begin
                            back.month = MONTH_TOP;
                            back.year  = (cur.year == '0) ? YEAR_TOP : cur.year - 14'd1;
                            back.day   = month_len(MONTH_TOP, leap);
                        end else begin
                            back.month = mon_dec;
                            back.day   = month_len(mon_dec, leap);
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        case (func)
            FUNC_FWD:  nxt = fwd;
            FUNC_BACK: nxt = back;
            FUNC_LOAD: nxt = load;
            default:   nxt = cur;
        endcase
    end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the calendar clock counter unit: directed table, then random words.
`timescale 1ns / 1ps

module tb_top;
    import cccu_pkg::*;

    typedef struct {
        func_t     f;
        cal_time_t ld;
        bit        typed;
        cal_time_t want;
    } dir_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func        = '0;
    logic [5:0]  s_load_second = '0;
    logic [5:0]  s_load_minute = '0;
    logic [4:0]  s_load_hour   = '0;
    logic [4:0]  s_load_day    = '0;
    logic [3:0]  s_load_month  = '0;
    logic [13:0] s_load_year   = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [5:0]  m_cur_second;
    logic [5:0]  m_cur_minute;
    logic [4:0]  m_cur_hour;
    logic [4:0]  m_cur_day;
    logic [3:0]  m_cur_month;
    logic [13:0] m_cur_year;

    cal_time_t pending_times[$];
    cal_time_t clock_model;
    dir_row_t  dir_rows[$];
    int        errors     = 0;
    int        sent       = 0;
    bit        calm       = 1'b0;
    bit        drain_hold = 1'b0;

    always #5 aclk = ~aclk;

    calendar_clock_up_down_counter_unit uut (.*);

    function automatic cal_time_t stamp(int y, int mo, int d, int h, int mi, int s);
        cal_time_t t;
        t.year   = 14'(y);
        t.month  = 4'(mo);
        t.day    = 5'(d);
        t.hour   = 5'(h);
        t.minute = 6'(mi);
        t.second = 6'(s);
        return t;
    endfunction

    function automatic logic [4:0] days_in(logic [3:0] mon, logic [13:0] yr);
        case (mon)
            4'd2: begin
                if (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0)) return 5'd29;
                return 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
            default: return 5'd0;
        endcase
    endfunction

    function automatic cal_time_t clock_step(cal_time_t t, func_t f, cal_time_t ld);
        case (f)
            FUNC_FWD: begin
                if (t.second < SEC_TOP) begin
                    t.second = t.second + 6'd1;
                end else begin
                    t.second = '0;
                    if (t.minute < MIN_TOP) begin
                        t.minute = t.minute + 6'd1;
                    end else begin
                        t.minute = '0;
                        if (t.hour < HOUR_TOP) begin
                            t.hour = t.hour + 5'd1;
                        end else begin
                            t.hour = '0;
                            if (int'(t.day) + 1 > int'(days_in(t.month, t.year))) begin
                                t.day = 5'd1;
                                if (t.month >= MONTH_TOP) begin
                                    t.month = 4'd1;
                                    t.year  = (t.year >= YEAR_TOP) ? 14'd0 : t.year + 14'd1;
                                end else begin
                                    t.month = t.month + 4'd1;
                                end
                            end else begin
                                t.day = t.day + 5'd1;
                            end
                        end
                    end
                end
            end
            FUNC_BACK: begin
                if (t.second != 0) begin
                    t.second = t.second - 6'd1;
                end else begin
                    t.second = SEC_TOP;
                    if (t.minute != 0) begin
                        t.minute = t.minute - 6'd1;
                    end else begin
                        t.minute = MIN_TOP;
                        if (t.hour != 0) begin
                            t.hour = t.hour - 5'd1;
                        end else begin
                            t.hour = HOUR_TOP;
                            t.day  = t.day - 5'd1;
                            if (t.day == 0) begin
                                t.month = t.month - 4'd1;
                                if (t.month == 0) begin
                                    t.month = MONTH_TOP;
                                    t.year  = (t.year == 0) ? YEAR_TOP : t.year - 14'd1;
                                end
                                t.day = days_in(t.month, t.year);
                            end
                        end
                    end
                end
            end
            FUNC_LOAD: t = ld;
            default: ;
        endcase
        return t;
    endfunction

    function automatic cal_time_t noise();
        logic [39:0] raw;
        raw[31:0]  = $urandom;
        raw[39:32] = 8'($urandom);
        return cal_time_t'(raw);
    endfunction

    // legal date/time, often near a day, month or year edge
    function automatic cal_time_t boundary_stamp();
        int y;
        int mo;
        int d;
        int len;
        case ($urandom_range(0, 8))
            0: y = 0;
            1: y = 9999;
            2: y = 1900;
            3: y = 2000;
            4: y = 2100;
            5: y = 2400;
            6: y = 4 * $urandom_range(0, 2499);
            default: y = $urandom_range(0, 9999);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: mo = 1;
                1: mo = 2;
                default: mo = 12;
            endcase
        end else begin
            mo = $urandom_range(1, 12);
        end
        len = days_in(4'(mo), 14'(y));
        case ($urandom_range(0, 2))
            0: d = len;
            1: d = 1;
            default: d = $urandom_range(1, len);
        endcase
        case ($urandom_range(0, 2))
            0: return stamp(y, mo, d, 23, 59, $urandom_range(55, 59));
            1: return stamp(y, mo, d, 0, 0, $urandom_range(0, 4));
            default: return stamp(y, mo, d, $urandom_range(0, 23), $urandom_range(0, 59),
                                  $urandom_range(0, 59));
        endcase
    endfunction

    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic add_row(func_t f, cal_time_t ld, bit typed, cal_time_t want);
        dir_row_t r;
        r.f     = f;
        r.ld    = ld;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    task automatic push_word(func_t f, cal_time_t ld, bit typed, cal_time_t want);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= f;
        s_load_second <= ld.second;
        s_load_minute <= ld.minute;
        s_load_hour   <= ld.hour;
        s_load_day    <= ld.day;
        s_load_month  <= ld.month;
        s_load_year   <= ld.year;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        clock_model = clock_step(clock_model, f, ld);
        pending_times.push_back(typed ? want : clock_model);
        sent++;
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        wait (pending_times.size() == 0);
        @(posedge aclk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : watch
        cal_time_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_times.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                want = pending_times.pop_front();
                check_field("cur_second", want.second, m_cur_second);
                check_field("cur_minute", want.minute, m_cur_minute);
                check_field("cur_hour", want.hour, m_cur_hour);
                check_field("cur_day", want.day, m_cur_day);
                check_field("cur_month", want.month, m_cur_month);
                check_field("cur_year", want.year, m_cur_year);
            end
        end
    end

    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (drain_hold) begin
                m_ready <= 1'b0;
                repeat (250) @(posedge aclk);
                drain_hold = 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    initial begin : stimulus
        int    n;
        int    mode;
        func_t f;

        add_row(FUNC_FWD, '0, 1'b1, stamp(2000, 1, 1, 0, 0, 1));
        add_row(FUNC_BACK, '0, 1'b1, stamp(2000, 1, 1, 0, 0, 0));
        add_row(FUNC_BACK, '0, 1'b1, stamp(1999, 12, 31, 23, 59, 59));
        add_row(FUNC_FWD, '0, 1'b1, stamp(2000, 1, 1, 0, 0, 0));
        add_row(FUNC_HOLD, '1, 1'b1, stamp(2000, 1, 1, 0, 0, 0));
        add_row(FUNC_LOAD, stamp(9999, 12, 31, 23, 59, 59), 1'b1, stamp(9999, 12, 31, 23, 59, 59));
        add_row(FUNC_FWD, '0, 1'b1, stamp(0, 1, 1, 0, 0, 0));
        add_row(FUNC_BACK, '0, 1'b1, stamp(9999, 12, 31, 23, 59, 59));
        add_row(FUNC_LOAD, stamp(2000, 2, 28, 23, 59, 59), 1'b1, stamp(2000, 2, 28, 23, 59, 59));
        add_row(FUNC_FWD, '0, 1'b0, '0);
        add_row(FUNC_FWD, '0, 1'b0, '0);
        add_row(FUNC_LOAD, stamp(1900, 2, 28, 23, 59, 59), 1'b1, stamp(1900, 2, 28, 23, 59, 59));
        add_row(FUNC_FWD, '0, 1'b0, '0);
        add_row(FUNC_LOAD, stamp(2024, 3, 1, 0, 0, 0), 1'b1, stamp(2024, 3, 1, 0, 0, 0));
        add_row(FUNC_BACK, '0, 1'b0, '0);
        add_row(FUNC_LOAD, stamp(2023, 3, 1, 0, 0, 0), 1'b1, stamp(2023, 3, 1, 0, 0, 0));
        add_row(FUNC_BACK, '0, 1'b0, '0);
        add_row(FUNC_LOAD, '1, 1'b1, '1);
        add_row(FUNC_FWD, '0, 1'b0, '0);
        add_row(FUNC_LOAD, '0, 1'b1, '0);
        add_row(FUNC_BACK, '0, 1'b0, '0);
        add_row(FUNC_LOAD, stamp(2000, 0, 1, 0, 0, 0), 1'b1, stamp(2000, 0, 1, 0, 0, 0));
        add_row(FUNC_BACK, '0, 1'b0, '0);
        add_row(FUNC_LOAD, stamp(2001, 13, 1, 23, 59, 59), 1'b1, stamp(2001, 13, 1, 23, 59, 59));
        add_row(FUNC_FWD, '0, 1'b0, '0);

        clock_model = stamp(2000, 1, 1, 0, 0, 0);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            push_word(dir_rows[i].f, dir_rows[i].ld, dir_rows[i].typed, dir_rows[i].want);
        end

        // sink holds off while words keep coming, so the unit backs up
        pause_until_drained();
        drain_hold = 1'b1;
        calm       = 1'b1;
        repeat (30) push_word(FUNC_FWD, noise(), 1'b0, '0);
        calm = 1'b0;

        while (sent < 1100) begin
            calm = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 49) == 0) pause_until_drained();
            if ($urandom_range(0, 99) < 12) begin
                n = $urandom_range(1, 5);
                repeat (n) push_word(func_t'($urandom_range(0, 3)), noise(), 1'b0, '0);
            end else begin
                push_word(FUNC_LOAD, boundary_stamp(), 1'b0, '0);
                n    = $urandom_range(1, 24);
                mode = $urandom_range(0, 2);
                repeat (n) begin
                    case (mode)
                        0: f = FUNC_FWD;
                        1: f = FUNC_BACK;
                        default: f = func_t'($urandom_range(0, 3));
                    endcase
                    push_word(f, noise(), 1'b0, '0);
                end
            end
        end
        calm = 1'b0;

        pause_until_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
